// File: rtl/rcdt_pkg.sv
// Shared types and codes of the run-length compressed DFA transition table.
package rcdt_pkg;

  typedef enum logic {
    CMD_BUILD = 1'b0,
    CMD_STEP  = 1'b1
  } rcdt_cmd_e;

  typedef struct packed {
    rcdt_cmd_e  command;
    logic [7:0] state_id;
    logic [7:0] symbol;
    logic [7:0] next_target;
  } rcdt_in_t;

  typedef struct packed {
    logic [7:0] next_state;
  } rcdt_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;        // capture the accepted input beat
    logic rd_meta;     // read run count and bitmap row of the state
    logic commit;      // write back one build entry
    logic scan_start;  // arm the run scan
    logic scan;        // issue run reads
    logic res_zero;    // result is no transition
    logic res_hit;     // result is the target of the run just compared
    logic out_load;    // move the result into the output register
  } rcdt_ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_step;
    logic ok;
    logic bit_set;
    logic n_zero;
    logic scan_hit;
    logic scan_done;
  } rcdt_sts_t;

endpackage

// File: rtl/rcdt_if.sv
// Valid/ready channel interfaces for the input and result beats.
interface rcdt_in_if;
  logic               valid;
  logic               ready;
  rcdt_pkg::rcdt_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rcdt_out_if;
  logic                valid;
  logic                ready;
  rcdt_pkg::rcdt_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/rcdt_dp.sv
// Datapath: item registers, run/count/bitmap memories, scan and result registers.
module rcdt_dp #(
  parameter int NUM_STATES = 256,
  parameter int MAX_RUNS   = 128,
  parameter int ALPHABET   = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rcdt_pkg::rcdt_in_t in_payload_i,
  input  rcdt_pkg::rcdt_ctl_t ctl_i,
  output rcdt_pkg::rcdt_sts_t sts_o,
  output logic [7:0]         next_state_o
);
  import rcdt_pkg::*;

  localparam int NS  = (NUM_STATES < 256) ? NUM_STATES : 256;
  localparam int SW  = (NS > 1) ? $clog2(NS) : 1;
  localparam int AW  = $clog2(ALPHABET);
  localparam int CW  = $clog2(MAX_RUNS + 1);
  localparam int RAW = $clog2(NS * MAX_RUNS);

  // Item registers.
  rcdt_in_t item_q;
  logic     ok_q;

  // Memories.
  logic [7:0]          end_mem [NS*MAX_RUNS];
  logic [7:0]          tgt_mem [NS*MAX_RUNS];
  logic [CW-1:0]       cnt_mem [NS];
  logic [ALPHABET-1:0] bmp_mem [NS];
  logic [NS-1:0]       vld_q;

  // Read data.
  logic [CW-1:0]       cnt_rd_q;
  logic [ALPHABET-1:0] row_rd_q;
  logic                vld_rd_q;
  logic [7:0]          end_rd_q;
  logic [7:0]          tgt_rd_q;

  logic [7:0]    prev_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] idx_q;
  logic          issue_q;
  logic [7:0]    res_q;
  logic [7:0]    out_q;

  logic [SW-1:0]       st_idx;
  logic [AW-1:0]       sym_idx;
  logic [CW-1:0]       n_eff;
  logic [ALPHABET-1:0] row_eff;
  logic                sym_zero;
  logic [CW-1:0]       n_b;
  logic [ALPHABET-1:0] row_b;
  logic [7:0]          prev_b;
  logic                ext;
  logic                add;
  logic                set_bit;
  logic [CW-1:0]       cnt_new;
  logic [ALPHABET-1:0] row_new;
  logic [7:0]          prev_new;
  logic [RAW-1:0]      base;
  logic [RAW-1:0]      wr_addr;
  logic [RAW-1:0]      rd_addr;
  logic                in_ok;

  assign in_ok = (int'(in_payload_i.state_id) < NUM_STATES) &&
                 (int'(in_payload_i.symbol) < ALPHABET);

  assign st_idx  = item_q.state_id[SW-1:0];
  assign sym_idx = item_q.symbol[AW-1:0];
  assign n_eff   = vld_rd_q ? cnt_rd_q : '0;
  assign row_eff = vld_rd_q ? row_rd_q : '0;

  // Build decision; symbol zero starts the row afresh.
  always_comb begin
    sym_zero = (item_q.symbol == 8'd0);
    n_b      = sym_zero ? '0 : n_eff;
    row_b    = sym_zero ? '0 : row_eff;
    prev_b   = sym_zero ? 8'd0 : prev_q;
    ext      = (item_q.next_target != 8'd0) && (item_q.next_target == prev_b) &&
               (n_b != '0);
    add      = (item_q.next_target != 8'd0) && !ext && (n_b < CW'(MAX_RUNS));
    set_bit  = ext || add;
    cnt_new  = add ? CW'(n_b + CW'(1)) : n_b;
    row_new  = row_b | (set_bit ? ({{(ALPHABET-1){1'b0}}, 1'b1} << sym_idx) : '0);
    prev_new = set_bit ? item_q.next_target : 8'd0;
  end

  assign base    = RAW'(st_idx) * RAW'(MAX_RUNS);
  assign wr_addr = base + (ext ? RAW'(CW'(n_b - CW'(1))) : RAW'(n_b));
  assign rd_addr = base + RAW'(idx_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      item_q <= in_payload_i;
      ok_q   <= in_ok;
    end
  end

  // Per-state count and bitmap row, read together.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_meta) begin
      cnt_rd_q <= cnt_mem[st_idx];
      row_rd_q <= bmp_mem[st_idx];
      vld_rd_q <= vld_q[st_idx];
    end
    if (ctl_i.commit) begin
      cnt_mem[st_idx] <= cnt_new;
      bmp_mem[st_idx] <= row_new;
    end
  end

  // Valid bit per state: an unwritten row reads as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      prev_q <= 8'd0;
    end else if (ctl_i.commit) begin
      vld_q[st_idx] <= 1'b1;
      prev_q        <= prev_new;
    end
  end

  // Run store: end symbol and target per run.
  always_ff @(posedge clk_i) begin
    if (ctl_i.commit && set_bit) begin
      end_mem[wr_addr] <= item_q.symbol;
    end
    if (ctl_i.commit && add) begin
      tgt_mem[wr_addr] <= item_q.next_target;
    end
    if (ctl_i.scan && (idx_q < cnt_q)) begin
      end_rd_q <= end_mem[rd_addr];
      tgt_rd_q <= tgt_mem[rd_addr];
    end
  end

  // Scan pointer: issue one read a cycle, compare the one before.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else if (ctl_i.scan_start) begin
      issue_q <= 1'b0;
      idx_q   <= '0;
      cnt_q   <= n_eff;
    end else if (ctl_i.scan) begin
      issue_q <= (idx_q < cnt_q);
      if (idx_q < cnt_q) begin
        idx_q <= CW'(idx_q + CW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_zero) begin
      res_q <= 8'd0;
    end else if (ctl_i.res_hit) begin
      res_q <= tgt_rd_q;
    end
    if (ctl_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign next_state_o = out_q;

  always_comb begin
    sts_o.is_step   = (item_q.command == CMD_STEP);
    sts_o.ok        = ok_q;
    sts_o.bit_set   = row_eff[sym_idx];
    sts_o.n_zero    = (n_eff == '0);
    sts_o.scan_hit  = issue_q && (item_q.symbol <= end_rd_q);
    sts_o.scan_done = !issue_q && (idx_q == cnt_q);
  end

endmodule

// File: rtl/rcdt_ctrl.sv
// Controller: sequences accept, metadata read, build commit, run scan and output.
module rcdt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  rcdt_pkg::rcdt_sts_t sts_i,
  output rcdt_pkg::rcdt_ctl_t ctl_o
);
  import rcdt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       out_valid_q;
  logic       out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        if (!sts_i.ok) begin
          if (sts_i.is_step) begin
            ctl_o.res_zero = 1'b1;
            state_d        = S_OUT;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          ctl_o.rd_meta = 1'b1;
          state_d       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts_i.is_step) begin
          ctl_o.commit = 1'b1;
          state_d      = S_IDLE;
        end else if (!sts_i.bit_set || sts_i.n_zero) begin
          ctl_o.res_zero = 1'b1;
          state_d        = S_OUT;
        end else begin
          ctl_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl_o.scan = 1'b1;
        if (sts_i.scan_hit) begin
          ctl_o.res_hit = 1'b1;
          state_d       = S_OUT;
        end else if (sts_i.scan_done) begin
          ctl_o.res_zero = 1'b1;
          state_d        = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctl_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/range_compressed_dfa_transition.sv
// Run-length compressed DFA transition table, top level: a build beat is accepted, the
// state's run count and bitmap row are read, and the entry is written back; a build
// beat whose state or symbol is out of range is dropped after the accept. A step beat
// is accepted, its count and row are read, and the stored runs are scanned until one
// reaches the byte or none is left; a clear bitmap bit gives no transition without a
// scan, and a state or byte out of range gives it without the read. The run store has
// one read port and is walked one run per cycle. One beat is worked at a time; the
// result sits in an output register, so a new beat is taken while the last result waits,
// and a lookup that finishes while it still waits holds until the result beat is taken.
module range_compressed_dfa_transition #(
  parameter int NUM_STATES = 256,
  parameter int MAX_RUNS   = 128,
  parameter int ALPHABET   = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rcdt_in_if.sink    in_i,
  rcdt_out_if.source out_o
);
  import rcdt_pkg::*;

  rcdt_ctl_t  ctl;
  rcdt_sts_t  sts;
  logic [7:0] next_state;

  // Sequence every beat through the controller; the datapath only obeys commands.
  rcdt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // Hold the stores, the scan pointer and the result register.
  rcdt_dp #(
    .NUM_STATES (NUM_STATES),
    .MAX_RUNS   (MAX_RUNS),
    .ALPHABET   (ALPHABET)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_payload_i (in_i.payload),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .next_state_o (next_state)
  );

  assign out_o.payload.next_state = next_state;

endmodule

// File: rtl/rcdt_chk.sv
// Port-level checker for the compressed DFA table, bound to the top level.
module rcdt_chk (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input rcdt_pkg::rcdt_cmd_e   in_command_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [7:0]            out_next_state_i
);
  import rcdt_pkg::*;

  // One beat at a time: no accept in the cycle after an accept.
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted twice back to back");

  // A build beat never raises a result.
  a_build_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_command_i == CMD_BUILD) && !out_valid_i)
      |=> !out_valid_i)
    else $error("result raised by a build beat");

  // A new result appears only while the input side is busy.
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a lookup in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_next_state_i))
    else $error("result changed while stalled");

endmodule

bind range_compressed_dfa_transition rcdt_chk u_rcdt_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_command_i     (in_i.payload.command),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_next_state_i (out_o.payload.next_state)
);
